/* src/mfcb_pkg.sv */
// ----------------------------------------------------------------------------
// mfcb_pkg: shared types and constants for the frame change box extractor
// Character codes, line phase encoding, header number tracking and
// configuration register indexes.
// ----------------------------------------------------------------------------
package mfcb_pkg;

   // character codes
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_AT    = 8'h40;

   // configuration register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [6:0] FRAME_WIDTH_RESET  = 7'd18;
   localparam logic [6:0] FRAME_HEIGHT_RESET = 7'd8;

   // header number stages
   localparam logic [1:0] NUM_IDLE   = 2'd0;
   localparam logic [1:0] NUM_SIGN   = 2'd1;
   localparam logic [1:0] NUM_DIGITS = 2'd2;
   localparam logic [1:0] NUM_DONE   = 2'd3;

   localparam logic [15:0] DURATION_MAX = 16'hFFFF;

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [16:0] DIV10_RECIP = 17'd52429;
   localparam int          DIV10_SHIFT = 19;

   typedef enum logic [3:0] {
      PH_SKIP   = 4'b0001,
      PH_HEADER = 4'b0010,
      PH_ROW    = 4'b0100,
      PH_ABORT  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic       neg;
      logic [1:0] stage;
   } num_state_type;

endpackage

/* src/mfcb_num_parse.sv */
// ----------------------------------------------------------------------------
// mfcb_num_parse: header duration parser
// One character step of the '@' line number: blanks, optional sign, decimal
// digits with saturation at 16 bits.
// ----------------------------------------------------------------------------
module mfcb_num_parse
   import mfcb_pkg::*;
(
   input  logic [7:0]    text_byte,
   input  logic [15:0]   dur,
   input  num_state_type num,
   output logic [15:0]   dur_next,
   output num_state_type num_next
);

   logic        is_digit;
   logic        is_blank;
   logic        is_sign;
   logic [19:0] scaled;

   assign is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
   assign is_blank = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB) ||
                     (text_byte == CHAR_VT) || (text_byte == CHAR_FF);
   assign is_sign  = (text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS);

   // dur * 10 + digit
   assign scaled = 20'({dur, 3'b000}) + 20'({dur, 1'b0}) + 20'(text_byte[3:0]);

   always_comb begin
      dur_next = dur;
      num_next = num;
      priority if (num.stage == NUM_DONE) begin
         // number finished, ignore the rest of the line
      end else if (is_digit) begin
         dur_next       = (scaled[19:16] != 4'd0) ? DURATION_MAX : scaled[15:0];
         num_next.stage = NUM_DIGITS;
      end else if (num.stage == NUM_IDLE && is_blank) begin
         // leading blank
      end else if (num.stage == NUM_IDLE && is_sign) begin
         num_next.stage = NUM_SIGN;
         num_next.neg   = (text_byte == CHAR_MINUS);
      end else begin
         num_next.stage = NUM_DONE;
      end
   end

endmodule

/* src/mfcb_row_store.sv */
// ----------------------------------------------------------------------------
// mfcb_row_store: frame pixel store
// One row per entry, one write and one registered read per cycle. Per-row
// valid bits make unwritten rows read as all off; a write to the row being
// read is forwarded.
// ----------------------------------------------------------------------------
module mfcb_row_store #(
   parameter  int DEPTH = 64,
   parameter  int WIDTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [AW-1:0]    rd_addr,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         rd_data_ff <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (wr_en && wr_addr == rd_addr) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/movie_frame_change_box_top.sv */
// ----------------------------------------------------------------------------
// movie_frame_change_box_top: changed-pixel box extractor for a text movie
// Parses the movie text byte stream and reports, per frame, the box of
// pixels that changed and the frame delay.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle, sustained, and delivers a result
// through the input register and then the result register after the byte
// that ends a frame line is accepted. A result is produced only
// on a line-ending byte: a completed frame with its change box and delay, or
// an invalid-frame marker with all other fields zero. The result register
// decouples the two sides, so new bytes keep flowing while a result waits;
// the input only stalls when a byte is ready to be processed and the result
// register is still occupied. The per-byte path is one compare against the
// current stored row, which the pixel store presents from a registered read
// of the next row index, plus small counter and bound updates. The pixel
// store clears through per-row valid bits at reset, so there is no clearing
// pass. Configuration (frame width and height) must be written only while no
// request is in flight.
// ----------------------------------------------------------------------------
module movie_frame_change_box_top
   import mfcb_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [5:0]  rsp_box_left,
   output logic [5:0]  rsp_box_top,
   output logic [6:0]  rsp_box_width,
   output logic [6:0]  rsp_box_height,
   output logic [12:0] rsp_frame_delay,
   // configuration
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RIW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam logic [6:0] MAX_W7 = 7'(MAX_WIDTH);
   localparam logic [6:0] MAX_H7 = 7'(MAX_HEIGHT);

   // configuration registers
   logic [6:0] cfg_width_ff;
   logic [6:0] cfg_height_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic [5:0]  rsp_left_ff;
   logic [5:0]  rsp_top_ff;
   logic [6:0]  rsp_width_ff;
   logic [6:0]  rsp_height_ff;
   logic [12:0] rsp_delay_ff;

   // parser state
   logic [MAX_WIDTH-1:0] row_buf_ff, row_buf_in;
   logic [6:0]           char_count_ff, char_count_in;
   logic [RIW-1:0]       row_index_ff, row_index_in;
   phase_type            phase_ff, phase_in;
   logic                 inside_ff, inside_in;
   logic                 at_start_ff, at_start_in;
   logic                 after_cr_ff, after_cr_in;
   logic [15:0]          dur_ff, dur_in;
   num_state_type        num_ff, num_in;
   logic [6:0]           cb_left_ff, cb_left_in;
   logic [6:0]           cb_top_ff, cb_top_in;
   logic [6:0]           cb_right_ff, cb_right_in;
   logic [6:0]           cb_bottom_ff, cb_bottom_in;
   logic                 first_ff, first_in;
   logic [CW-1:0]        rb_left_ff, rb_left_in;
   logic [6:0]           rb_right_ff, rb_right_in;
   logic [12:0]          delay_ff;

   // datapath
   logic                 fire;
   logic [6:0]           w_eff;
   logic [6:0]           h_eff;
   logic [7:0]           c;
   logic [MAX_WIDTH-1:0] row_rd;
   logic [MAX_WIDTH-1:0] commit_mask;
   logic [MAX_WIDTH-1:0] wr_data;
   logic                 wr_en;
   logic [32:0]          div_prod;
   logic [15:0]          hdr_dur;
   num_state_type        hdr_num;

   // per-character row update
   logic                 col_ok;
   logic [CW-1:0]        col;
   logic                 pix_on;
   logic                 pix_diff;
   logic [CW-1:0]        rc_left;
   logic [6:0]           rc_right;
   logic [MAX_WIDTH-1:0] rc_buf;
   logic [6:0]           rc_count;

   // commit path
   logic [6:0] row_ext;
   logic [6:0] row_next;
   logic [6:0] nl, nr, nt, nb;

   // result next values
   logic        res_produce;
   logic        res_kind;
   logic [5:0]  res_left;
   logic [5:0]  res_top;
   logic [6:0]  res_width;
   logic [6:0]  res_height;
   logic [12:0] res_delay;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= FRAME_WIDTH_RESET;
         cfg_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  cfg_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: cfg_height_ff <= csr_data;
         endcase
      end
   end

   // out-of-range sizes clamp to 1..max
   assign w_eff = (cfg_width_ff == 7'd0) ? 7'd1 :
                  (cfg_width_ff > MAX_W7) ? MAX_W7 : cfg_width_ff;
   assign h_eff = (cfg_height_ff == 7'd0) ? 7'd1 :
                  (cfg_height_ff > MAX_H7) ? MAX_H7 : cfg_height_ff;

   // ------------------------------------------------------------- handshake
   // process the held byte unless a result would have nowhere to go
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_text_byte;
      end
   end

   assign c = in_byte_ff;

   // duration/10 is precomputed; the duration is stable for the whole frame
   assign div_prod = 33'(dur_ff) * 33'(DIV10_RECIP);

   always_ff @(posedge clock) begin
      delay_ff <= div_prod[DIV10_SHIFT+12:DIV10_SHIFT];
   end

   // ------------------------------------------------------------ submodules
   mfcb_num_parse u_num_parse (
      .text_byte (c),
      .dur       (dur_ff),
      .num       (num_ff),
      .dur_next  (hdr_dur),
      .num_next  (hdr_num)
   );

   mfcb_row_store #(
      .DEPTH (MAX_HEIGHT),
      .WIDTH (MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (row_index_in),
      .wr_en   (wr_en),
      .wr_addr (row_index_ff),
      .wr_data (wr_data),
      .rd_data (row_rd)
   );

   // ---------------------------------------------------------- row commit
   always_comb begin
      for (int j = 0; j < MAX_WIDTH; j++) begin
         commit_mask[j] = (7'(j) < w_eff);
      end
   end

   assign wr_data = (row_rd & ~commit_mask) | (row_buf_ff & commit_mask);

   // ------------------------------------------------------- row character
   assign col_ok   = (char_count_ff < w_eff);
   assign col      = char_count_ff[CW-1:0];
   assign pix_on   = (c == CHAR_ONE);
   assign pix_diff = (pix_on != row_rd[col]);

   always_comb begin
      rc_left  = rb_left_ff;
      rc_right = rb_right_ff;
      rc_buf   = row_buf_ff;
      if (col_ok) begin
         if (pix_diff) begin
            if (rb_right_ff == 7'd0 || col < rb_left_ff) begin
               rc_left = col;
            end
            if (7'(col) + 7'd1 > rb_right_ff) begin
               rc_right = 7'(col) + 7'd1;
            end
         end
         if (pix_on) begin
            rc_buf[col] = 1'b1;
         end
      end
      rc_count = (char_count_ff == 7'd127) ? char_count_ff : char_count_ff + 7'd1;
   end

   // box merged with the current row's changes
   assign row_ext  = 7'(row_index_ff);
   assign row_next = row_ext + 7'd1;

   always_comb begin
      nl = cb_left_ff;
      nr = cb_right_ff;
      nt = cb_top_ff;
      nb = cb_bottom_ff;
      if (rb_right_ff != 7'd0) begin
         if (7'(rb_left_ff) < cb_left_ff) nl = 7'(rb_left_ff);
         if (rb_right_ff > cb_right_ff)   nr = rb_right_ff;
         if (row_ext < cb_top_ff)         nt = row_ext;
         if (row_next > cb_bottom_ff)     nb = row_next;
      end
   end

   // ------------------------------------------------------- byte handling
   always_comb begin
      row_buf_in    = row_buf_ff;
      char_count_in = char_count_ff;
      row_index_in  = row_index_ff;
      phase_in      = phase_ff;
      inside_in     = inside_ff;
      at_start_in   = at_start_ff;
      after_cr_in   = after_cr_ff;
      dur_in        = dur_ff;
      num_in        = num_ff;
      cb_left_in    = cb_left_ff;
      cb_top_in     = cb_top_ff;
      cb_right_in   = cb_right_ff;
      cb_bottom_in  = cb_bottom_ff;
      first_in      = first_ff;
      rb_left_in    = rb_left_ff;
      rb_right_in   = rb_right_ff;
      wr_en         = 1'b0;
      res_produce   = 1'b0;
      res_kind      = 1'b0;
      res_left      = 6'd0;
      res_top       = 6'd0;
      res_width     = 7'd0;
      res_height    = 7'd0;
      res_delay     = 13'd0;

      if (fire) begin
         after_cr_in = 1'b0;
         priority if (after_cr_ff && c == CHAR_LF) begin
            // LF of a CR LF pair: already handled
         end else if (c == CHAR_CR || c == CHAR_LF) begin
            after_cr_in = (c == CHAR_CR);
            // end of line
            if (!at_start_ff && phase_ff == PH_HEADER) begin
               if (!num_ff.neg && dur_ff != 16'd0) begin
                  inside_in    = 1'b1;
                  row_index_in = '0;
               end
            end else if (inside_ff) begin
               if (at_start_ff || phase_ff != PH_ROW || char_count_ff < w_eff) begin
                  // short row, empty line or '@' line: abort
                  res_produce = 1'b1;
                  res_kind    = 1'b1;
                  inside_in   = 1'b0;
               end else begin
                  wr_en        = 1'b1;
                  cb_left_in   = nl;
                  cb_right_in  = nr;
                  cb_top_in    = nt;
                  cb_bottom_in = nb;
                  row_index_in = row_next[RIW-1:0];
                  if (row_next >= h_eff) begin
                     res_produce = 1'b1;
                     if (first_ff) begin
                        res_width  = w_eff;
                        res_height = h_eff;
                     end else if (nr == 7'd0) begin
                        // nothing changed: dummy box
                        res_width  = 7'd1;
                        res_height = 7'd1;
                     end else begin
                        res_left   = nl[5:0];
                        res_top    = nt[5:0];
                        res_width  = nr - nl;
                        res_height = nb - nt;
                     end
                     res_delay    = delay_ff;
                     cb_left_in   = MAX_W7;
                     cb_top_in    = MAX_H7;
                     cb_right_in  = 7'd0;
                     cb_bottom_in = 7'd0;
                     first_in     = 1'b0;
                     inside_in    = 1'b0;
                     row_index_in = '0;
                  end
               end
            end
            at_start_in   = 1'b1;
            phase_in      = PH_SKIP;
            char_count_in = 7'd0;
            row_buf_in    = '0;
            rb_left_in    = '0;
            rb_right_in   = 7'd0;
         end else if (at_start_ff) begin
            at_start_in = 1'b0;
            if (inside_ff) begin
               if (c == CHAR_AT) begin
                  phase_in = PH_ABORT;
               end else begin
                  // first character of a row line
                  phase_in      = PH_ROW;
                  row_buf_in    = rc_buf;
                  rb_left_in    = rc_left;
                  rb_right_in   = rc_right;
                  char_count_in = rc_count;
               end
            end else if (c == CHAR_AT) begin
               phase_in = PH_HEADER;
               dur_in   = 16'd0;
               num_in   = '0;
            end else begin
               phase_in = PH_SKIP;
            end
         end else if (phase_ff == PH_HEADER) begin
            dur_in = hdr_dur;
            num_in = hdr_num;
         end else if (phase_ff == PH_ROW) begin
            row_buf_in    = rc_buf;
            rb_left_in    = rc_left;
            rb_right_in   = rc_right;
            char_count_in = rc_count;
         end else begin
            // skipped or aborting line
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_buf_ff    <= '0;
         char_count_ff <= 7'd0;
         row_index_ff  <= '0;
         phase_ff      <= PH_SKIP;
         inside_ff     <= 1'b0;
         at_start_ff   <= 1'b1;
         after_cr_ff   <= 1'b0;
         dur_ff        <= 16'd0;
         num_ff        <= '0;
         cb_left_ff    <= MAX_W7;
         cb_top_ff     <= MAX_H7;
         cb_right_ff   <= 7'd0;
         cb_bottom_ff  <= 7'd0;
         first_ff      <= 1'b1;
         rb_left_ff    <= '0;
         rb_right_ff   <= 7'd0;
      end else begin
         row_buf_ff    <= row_buf_in;
         char_count_ff <= char_count_in;
         row_index_ff  <= row_index_in;
         phase_ff      <= phase_in;
         inside_ff     <= inside_in;
         at_start_ff   <= at_start_in;
         after_cr_ff   <= after_cr_in;
         dur_ff        <= dur_in;
         num_ff        <= num_in;
         cb_left_ff    <= cb_left_in;
         cb_top_ff     <= cb_top_in;
         cb_right_ff   <= cb_right_in;
         cb_bottom_ff  <= cb_bottom_in;
         first_ff      <= first_in;
         rb_left_ff    <= rb_left_in;
         rb_right_ff   <= rb_right_in;
      end
   end

   // ------------------------------------------------------ result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_produce) begin
         rsp_kind_ff   <= res_kind;
         rsp_left_ff   <= res_left;
         rsp_top_ff    <= res_top;
         rsp_width_ff  <= res_width;
         rsp_height_ff <= res_height;
         rsp_delay_ff  <= res_delay;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_box_left    = rsp_left_ff;
   assign rsp_box_top     = rsp_top_ff;
   assign rsp_box_width   = rsp_width_ff;
   assign rsp_box_height  = rsp_height_ff;
   assign rsp_frame_delay = rsp_delay_ff;

endmodule
